@@ hw/rtl/rmq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rank-matching message queue package
// Shared sizes, codes, controller/datapath interface types and width helpers.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // Queue sizing.
    localparam int QUEUE_DEPTH = 16;
    localparam int HANDLE_BITS = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Fixed port widths.
    localparam int RANK_W      = 16;
    localparam int MSG_OUT_W   = 32;
    localparam int CNT_OUT_W   = 5;

    // Operation codes.
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_PUSHED  = 2'd0,
        ST_POPPED  = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // Capture the incoming word.
        logic apply;  // Execute the captured word and register its result.
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // Output register can take a result this cycle.
    } t_dp_status;

    // Resize an incoming handle to the stored handle width.
    function automatic logic [HANDLE_BITS-1:0] handle_in(input logic [MSG_OUT_W-1:0] m);
        logic [HANDLE_BITS+MSG_OUT_W-1:0] w;
        w = (HANDLE_BITS + MSG_OUT_W)'(m);
        return w[HANDLE_BITS-1:0];
    endfunction

    // Resize a stored handle to the output port width.
    function automatic logic [MSG_OUT_W-1:0] handle_out(input logic [HANDLE_BITS-1:0] h);
        logic [HANDLE_BITS+MSG_OUT_W-1:0] w;
        w = (HANDLE_BITS + MSG_OUT_W)'(h);
        return w[MSG_OUT_W-1:0];
    endfunction

    // Resize the internal count to the output port width.
    function automatic logic [CNT_OUT_W-1:0] count_out(input logic [CNT_W-1:0] c);
        logic [CNT_W+CNT_OUT_W-1:0] w;
        w = (CNT_W + CNT_OUT_W)'(c);
        return w[CNT_OUT_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/rank_matching_message_queue_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Flow: an accepted word is captured, then executed into the output register;
// a new word is taken only after execution (capture, then compare/pick/compact in
// the slot registers), and execution waits while the output register is stalled.
// Reset: synchronous, active low; empties the queue and the output register.
// Slot contents are not cleared; only slots below the count are ever used.
// ----------------------------------------------------------------------------
// Rank-matching message queue
// Ordered queue of handles tagged by rank; push at the tail, pop the oldest
// entry with a matching rank and keep the order of the rest.
// ----------------------------------------------------------------------------
module rank_matching_message_queue_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_operation,
    input  wire logic [rmq_pkg::RANK_W-1:0]    i_rank,
    input  wire logic [rmq_pkg::MSG_OUT_W-1:0] i_message_handle,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [1:0]                         o_status,
    output logic [rmq_pkg::MSG_OUT_W-1:0]      o_message_out,
    output logic [rmq_pkg::CNT_OUT_W-1:0]      o_entry_count_out
);
    import rmq_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    t_status    status;

    localparam logic [CNT_OUT_W-1:0] FULL_COUNT_OUT = count_out(CNT_W'(QUEUE_DEPTH));

    // Sequencer.
    rmq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_dp_status (dp_status),
        .o_dp_cmd    (dp_cmd)
    );

    // Queue storage and result path.
    rmq_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_dp_cmd          (dp_cmd),
        .o_dp_status       (dp_status),
        .i_operation       (i_operation),
        .i_rank            (i_rank),
        .i_message_handle  (i_message_handle),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_status          (status),
        .o_message_out     (o_message_out),
        .o_entry_count_out (o_entry_count_out)
    );

    assign o_status = status;

    // One word in flight: an accepted word blocks the next one until it has been executed.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("Input accepted on back-to-back cycles.");

    // Only a successful pop carries a handle.
    a_msg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_POPPED)) |-> (o_message_out == '0))
        else $error("Nonzero handle on a result that is not a pop.");

    // A rejected push reports a full queue.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (o_entry_count_out == FULL_COUNT_OUT))
        else $error("Push rejected while the queue is not full.");

endmodule
`default_nettype wire

@@ hw/rtl/rmq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rank-matching message queue controller
// Two-state sequencer: accepts one word, then has the datapath execute it
// once the output register can take the result.
// ----------------------------------------------------------------------------
module rmq_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  rmq_pkg::t_dp_status     i_dp_status,
    output rmq_pkg::t_dp_cmd        o_dp_cmd
);
    import rmq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } t_state;

    t_state r_state;
    logic   r_stall;

    // Commands follow directly from the current state, the input valid and the free flag.
    always_comb begin
        o_dp_cmd.load  = (r_state == S_IDLE) && i_valid;
        o_dp_cmd.apply = (r_state == S_APPLY) && i_dp_status.out_free;
    end

    assign o_stall = r_stall;

    // State and the registered input stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_APPLY;
                        r_stall <= 1'b1;
                    end
                end
                S_APPLY: begin
                    if (i_dp_status.out_free) begin
                        r_state <= S_IDLE;
                        r_stall <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_stall <= 1'b0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/rmq_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rank-matching message queue datapath
// Slot registers with parallel rank compare, oldest-match pick, shift
// compaction on removal, and the registered output word.
// ----------------------------------------------------------------------------
module rmq_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  rmq_pkg::t_dp_cmd                   i_dp_cmd,
    output rmq_pkg::t_dp_status                o_dp_status,
    input  wire logic                          i_operation,
    input  wire logic [rmq_pkg::RANK_W-1:0]    i_rank,
    input  wire logic [rmq_pkg::MSG_OUT_W-1:0] i_message_handle,
    input  wire logic                          i_stall,
    output logic                               o_valid,
    output rmq_pkg::t_status                   o_status,
    output logic [rmq_pkg::MSG_OUT_W-1:0]      o_message_out,
    output logic [rmq_pkg::CNT_OUT_W-1:0]      o_entry_count_out
);
    import rmq_pkg::*;

    // Captured word.
    t_op                    r_op;
    logic [RANK_W-1:0]      r_rank;
    logic [HANDLE_BITS-1:0] r_handle;

    // Queue storage; slots at or above the count hold stale data.
    logic [HANDLE_BITS-1:0] r_slot_msg  [QUEUE_DEPTH];
    logic [RANK_W-1:0]      r_slot_rank [QUEUE_DEPTH];
    logic [CNT_W-1:0]       r_count;

    // Output register.
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [MSG_OUT_W-1:0]   r_out_msg;
    logic [CNT_OUT_W-1:0]   r_out_count;

    logic [QUEUE_DEPTH-1:0] match;
    logic [QUEUE_DEPTH-1:0] at_or_above;
    logic [QUEUE_DEPTH-1:0] first;
    logic [HANDLE_BITS-1:0] hit_msg;
    logic                   is_full;
    logic                   push_ok;
    logic                   pop_hit;
    t_status                n_status;
    logic [MSG_OUT_W-1:0]   n_msg;
    logic [CNT_W-1:0]       n_count;

    // Capture the accepted word.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_op     <= t_op'(i_operation);
            r_rank   <= i_rank;
            r_handle <= handle_in(i_message_handle);
        end
    end

    // Parallel compare and oldest-match pick.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            match[i] = (CNT_W'(i) < r_count) && (r_slot_rank[i] == r_rank);
        end
        at_or_above[0] = match[0];
        first[0]       = match[0];
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            at_or_above[i] = at_or_above[i-1] | match[i];
            first[i]       = match[i] & ~at_or_above[i-1];
        end
        hit_msg = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            hit_msg = hit_msg | (r_slot_msg[i] & {HANDLE_BITS{first[i]}});
        end
    end

    // Result of the captured operation.
    always_comb begin
        is_full = (r_count == CNT_W'(QUEUE_DEPTH));
        push_ok = (r_op == OP_PUSH) && !is_full;
        pop_hit = (r_op == OP_POP) && at_or_above[QUEUE_DEPTH-1];
        n_msg   = '0;
        n_count = r_count;
        if (r_op == OP_PUSH) begin
            if (is_full) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_PUSHED;
                n_count  = r_count + CNT_W'(1);
            end
        end else if (pop_hit) begin
            n_status = ST_POPPED;
            n_msg    = handle_out(hit_msg);
            n_count  = r_count - CNT_W'(1);
        end else begin
            n_status = ST_NOMATCH;
        end
    end

    // Slot update: append at the tail, or close the gap above the removed entry.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.apply) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (push_ok && (r_count == CNT_W'(i))) begin
                    r_slot_msg[i]  <= r_handle;
                    r_slot_rank[i] <= r_rank;
                end
            end
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                if (pop_hit && at_or_above[i]) begin
                    r_slot_msg[i]  <= r_slot_msg[i+1];
                    r_slot_rank[i] <= r_slot_rank[i+1];
                end
            end
        end
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_dp_cmd.apply) begin
            r_count <= n_count;
        end
    end

    // Output register: loaded on execute, emptied when the word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.apply) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.apply) begin
            r_out_status <= n_status;
            r_out_msg    <= n_msg;
            r_out_count  <= count_out(n_count);
        end
    end

    assign o_dp_status.out_free = !r_out_valid || !i_stall;
    assign o_valid              = r_out_valid;
    assign o_status             = r_out_status;
    assign o_message_out        = r_out_msg;
    assign o_entry_count_out    = r_out_count;

endmodule
`default_nettype wire

@@ tb/rank_matching_message_queue_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank-matching message queue testbench
// Drives push and pop words with random idle gaps and output stalls. A
// scoreboard mirrors the queue, predicts each result word and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module rank_matching_message_queue_unit_tb;
    import rmq_pkg::*;

    localparam int unsigned RANDOM_WORDS    = 1750;
    localparam int unsigned QUIET_FROM      = 1530;
    localparam int unsigned WATCHDOG_CYCLES = 2000;

    // One predicted result word.
    typedef struct {
        t_status               status;
        logic [MSG_OUT_W-1:0]  handle;
        logic [CNT_OUT_W-1:0]  count;
    } t_queue_reply;

    // Mirror of the queue contents and the replies still owed by the block.
    class t_rank_queue_mirror;
        logic [HANDLE_BITS-1:0] held_handle[QUEUE_DEPTH];
        logic [RANK_W-1:0]      held_rank[QUEUE_DEPTH];
        int unsigned            depth_used;
        t_queue_reply           pending_replies[$];
        int unsigned            error_count;

        function new();
            depth_used  = 0;
            error_count = 0;
        endfunction

        // Apply an accepted word to the mirror and queue up its reply.
        function void note_request(t_op op, logic [RANK_W-1:0] rank,
                                   logic [MSG_OUT_W-1:0] handle);
            t_queue_reply reply;
            int hit;
            reply.status = ST_NOMATCH;
            reply.handle = '0;
            hit = -1;
            if (op == OP_PUSH) begin
                if (depth_used >= QUEUE_DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    held_handle[depth_used] = HANDLE_BITS'(handle);
                    held_rank[depth_used]   = rank;
                    depth_used++;
                    reply.status = ST_PUSHED;
                end
            end else begin
                // The oldest entry with a matching rank wins.
                for (int i = 0; i < int'(depth_used); i++) begin
                    if (hit < 0 && held_rank[i] == rank) hit = i;
                end
                if (hit >= 0) begin
                    reply.status = ST_POPPED;
                    reply.handle = MSG_OUT_W'(held_handle[hit]);
                    // Close the gap so the younger entries keep their order.
                    for (int j = hit; j + 1 < int'(depth_used); j++) begin
                        held_handle[j] = held_handle[j + 1];
                        held_rank[j]   = held_rank[j + 1];
                    end
                    depth_used--;
                end
            end
            reply.count = CNT_OUT_W'(depth_used);
            pending_replies.push_back(reply);
        endfunction

        // Compare a returned word with the oldest outstanding reply.
        function void check_reply(logic [1:0] status, logic [MSG_OUT_W-1:0] handle,
                                  logic [CNT_OUT_W-1:0] count);
            t_queue_reply want;
            if (pending_replies.size() == 0) begin
                $error("result word with no request outstanding: status %0d", status);
                error_count++;
                return;
            end
            want = pending_replies.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                error_count++;
            end
            if (handle !== want.handle) begin
                $error("message_out: expected %08h, got %08h", want.handle, handle);
                error_count++;
            end
            if (count !== want.count) begin
                $error("entry_count_out: expected %0d, got %0d", want.count, count);
                error_count++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic                   i_operation;
    logic [RANK_W-1:0]      i_rank;
    logic [MSG_OUT_W-1:0]   i_message_handle;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [1:0]             o_status;
    logic [MSG_OUT_W-1:0]   o_message_out;
    logic [CNT_OUT_W-1:0]   o_entry_count_out;

    logic                   sender_gaps = 1'b0;
    logic                   stall_on = 1'b0;
    int unsigned            stall_hold = 0;
    int unsigned            quiet_cycles = 0;

    t_rank_queue_mirror     mirror = new();

    rank_matching_message_queue_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_operation       (i_operation),
        .i_rank            (i_rank),
        .i_message_handle  (i_message_handle),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_message_out     (o_message_out),
        .o_entry_count_out (o_entry_count_out)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watch both handshakes; predict on input words, check on result words.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                mirror.check_reply(o_status, o_message_out, o_entry_count_out);
            end
            if (i_valid && !o_stall) begin
                mirror.note_request(t_op'(i_operation), i_rank, i_message_handle);
            end
        end
    end

    // Output stalls start at random and last for a randomly drawn hold count.
    always @(posedge i_clk) begin
        if (!i_rst_n || !stall_on) begin
            i_stall    <= 1'b0;
            stall_hold <= 0;
        end else if (stall_hold != 0) begin
            i_stall    <= 1'b1;
            stall_hold <= stall_hold - 1;
        end else if ($urandom_range(0, 11) == 0) begin
            i_stall    <= 1'b1;
            stall_hold <= $urandom_range(0, 17);
        end else begin
            i_stall    <= 1'b0;
        end
    end

    // Give up when neither side has moved a word for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Present one word, with an optional idle burst first, and hold it until taken.
    task automatic send_word(input t_op op, input logic [RANK_W-1:0] rank,
                             input logic [MSG_OUT_W-1:0] handle);
        int unsigned gap;
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_operation      <= op;
        i_rank           <= rank;
        i_message_handle <= handle;
        do @(posedge i_clk); while (o_stall);
    endtask

    initial begin
        logic [RANK_W-1:0] rank_pool[8];
        int unsigned       sent;
        int unsigned       seg_len;
        int unsigned       push_pct;
        int unsigned       pool_n;
        t_op               op;
        logic [RANK_W-1:0] rank;

        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_operation      <= OP_PUSH;
        i_rank           <= '0;
        i_message_handle <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        sender_gaps <= 1'b1;
        stall_on    <= 1'b1;

        // Pop on an empty queue, then the field extremes.
        send_word(OP_POP,  16'h0000, $urandom);
        send_word(OP_PUSH, 16'h0000, 32'h0000_0000);
        send_word(OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF);
        // Two entries with the same rank: the older one must leave first.
        send_word(OP_PUSH, 16'h0005, 32'hA5A5_0001);
        send_word(OP_PUSH, 16'h0005, 32'h5A5A_0002);
        send_word(OP_POP,  16'h0005, $urandom);
        // A rank that is not queued, then removal from the middle.
        send_word(OP_POP,  16'h0007, $urandom);
        send_word(OP_POP,  16'hFFFF, $urandom);
        // Fill the queue and push once more into the full queue.
        for (int i = 0; i < QUEUE_DEPTH - 2; i++) begin
            send_word(OP_PUSH, 16'h8000 | RANK_W'(i), $urandom);
        end
        send_word(OP_PUSH, 16'h1234, $urandom);
        // Remove the head and then the tail.
        send_word(OP_POP,  16'h0000, $urandom);
        send_word(OP_POP,  16'h8000 | RANK_W'(QUEUE_DEPTH - 3), $urandom);

        // Random segments, each with its own push mix, rank pool and idling.
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            seg_len  = $urandom_range(20, 80);
            push_pct = $urandom_range(10, 90);
            pool_n   = $urandom_range(1, 8);
            for (int p = 0; p < 8; p++) begin
                case ($urandom_range(0, 2))
                    0:       rank_pool[p] = RANK_W'($urandom_range(0, 3));
                    1:       rank_pool[p] = RANK_W'($urandom_range(0, 16'hFFFF));
                    default: rank_pool[p] = 16'hFFFF ^ RANK_W'($urandom_range(0, 3));
                endcase
            end
            if (sent >= QUIET_FROM) begin
                sender_gaps <= 1'b0;
                stall_on    <= 1'b0;
            end else begin
                sender_gaps <= ($urandom_range(0, 3) != 0);
                stall_on    <= ($urandom_range(0, 3) != 0);
            end
            for (int k = 0; k < int'(seg_len) && sent < RANDOM_WORDS; k++) begin
                op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                // Mostly pool ranks so pops hit; now and then any rank at all.
                if ($urandom_range(0, 9) == 0) begin
                    rank = RANK_W'($urandom_range(0, 16'hFFFF));
                end else begin
                    rank = rank_pool[$urandom_range(0, pool_n - 1)];
                end
                send_word(op, rank, $urandom);
                sent++;
            end
        end
        i_valid <= 1'b0;

        // Drain the remaining result words, then let the pipeline settle.
        while (mirror.pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mirror.error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
